// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the block cache rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/core/bfbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfbc_pkg
// sizes, codes and shared types of the best-fit block cache
// ----------------------------------------------------------------------------
package bfbc_pkg;

  localparam int unsigned POOL_DEPTH = 16;
  localparam int unsigned IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned HELD_W     = 5;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT    = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_CACHED = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic             clr;
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } scan_res_t;

endpackage

// ----- rtl/core/bfbc_scan.sv -----
// ----------------------------------------------------------------------------
// bfbc_scan
// best-fit tracker: compares one pool entry a cycle against the request
// ----------------------------------------------------------------------------
module bfbc_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfbc_pkg::scan_ctrl_t         ctrl_i,
  input  logic [bfbc_pkg::SIZE_W-1:0]  want_i,
  input  logic [bfbc_pkg::SIZE_W-1:0]  size_i,
  input  logic [bfbc_pkg::ADDR_W-1:0]  addr_i,
  output bfbc_pkg::scan_res_t          res_o
);

  logic                         found_q;
  logic [bfbc_pkg::IDX_W-1:0]   idx_q;
  logic [bfbc_pkg::SIZE_W-1:0]  size_q;
  logic [bfbc_pkg::ADDR_W-1:0]  addr_q;
  logic                         take;

  assign take = ctrl_i.vld && (size_i >= want_i) && (!found_q || (size_i < size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clr) begin
      idx_q  <= ctrl_i.idx;
      size_q <= size_i;
      addr_q <= addr_i;
    end
  end

  assign res_o.found = found_q;
  assign res_o.idx   = idx_q;
  assign res_o.size  = size_q;
  assign res_o.addr  = addr_q;

endmodule

// ----- rtl/core/best_fit_block_cache_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_cache_unit
// pool of up to 16 cached blocks (address, size) with best-fit get and put
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result beat on done_o, which the receiver must take in that
// cycle. A put, and a get on an empty pool, answer in the cycle after the
// request. A get walks the pool one entry a cycle through a single memory read
// port and one comparator. A miss answers from ST_DECIDE, a hit from ST_MOVE
// after the last entry is read; busy drops with the result beat. The entry
// handed out is replaced by the last entry of the pool.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_fit_block_cache_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [bfbc_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [bfbc_pkg::ADDR_W-1:0]  block_address_i,
  output logic                         done_o,
  output logic [bfbc_pkg::STATUS_W-1:0] status_o,
  output logic [bfbc_pkg::ADDR_W-1:0]  found_address_o,
  output logic [bfbc_pkg::SIZE_W-1:0]  found_size_o,
  output logic [bfbc_pkg::HELD_W-1:0]  entries_held_o
);

  localparam int unsigned CntW  = bfbc_pkg::CNT_W;
  localparam int unsigned IdxW  = bfbc_pkg::IDX_W;
  localparam int unsigned HeldW = bfbc_pkg::HELD_W;
  localparam logic [CntW-1:0] FullCnt = CntW'(bfbc_pkg::POOL_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_MOVE   = 2'd3;

  logic [bfbc_pkg::ADDR_W-1:0] addr_mem [bfbc_pkg::POOL_DEPTH];
  logic [bfbc_pkg::SIZE_W-1:0] size_mem [bfbc_pkg::POOL_DEPTH];

  logic [1:0]                   state_q, state_d;
  logic [CntW-1:0]              pool_count_q, pool_count_d;
  logic [CntW-1:0]              scan_idx_q, scan_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]              cmp_idx_q, cmp_idx_d;
  logic [bfbc_pkg::SIZE_W-1:0]  want_q, want_d;
  logic                         done_q, done_d;
  bfbc_pkg::status_e            status_q, status_d;
  logic [bfbc_pkg::ADDR_W-1:0]  fnd_addr_q, fnd_addr_d;
  logic [bfbc_pkg::SIZE_W-1:0]  fnd_size_q, fnd_size_d;
  logic [HeldW-1:0]             held_q, held_d;

  logic                         mem_we;
  logic [IdxW-1:0]              mem_waddr;
  logic [bfbc_pkg::ADDR_W-1:0]  mem_wdata_addr;
  logic [bfbc_pkg::SIZE_W-1:0]  mem_wdata_size;
  logic [IdxW-1:0]              mem_raddr;
  logic [bfbc_pkg::ADDR_W-1:0]  rd_addr_q;
  logic [bfbc_pkg::SIZE_W-1:0]  rd_size_q;

  logic [CntW-1:0]              cnt_m1;
  logic [IdxW-1:0]              last_idx;
  logic                         accept;
  bfbc_pkg::scan_ctrl_t         scan_ctrl;
  bfbc_pkg::scan_res_t          scan_res;

  assign accept   = start && !busy;
  assign cnt_m1   = pool_count_q - CntW'(1);
  assign last_idx = cnt_m1[IdxW-1:0];

  bfbc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .want_i (want_q),
    .size_i (rd_size_q),
    .addr_i (rd_addr_q),
    .res_o  (scan_res)
  );

  always_comb begin
    state_d        = state_q;
    pool_count_d   = pool_count_q;
    scan_idx_d     = scan_idx_q;
    cmp_vld_d      = 1'b0;
    cmp_idx_d      = cmp_idx_q;
    want_d         = want_q;
    done_d         = 1'b0;
    status_d       = status_q;
    fnd_addr_d     = fnd_addr_q;
    fnd_size_d     = fnd_size_q;
    mem_we         = 1'b0;
    mem_waddr      = pool_count_q[IdxW-1:0];
    mem_wdata_addr = block_address_i;
    mem_wdata_size = request_size_i;
    mem_raddr      = '0;
    scan_ctrl.clr  = 1'b0;
    scan_ctrl.vld  = cmp_vld_q;
    scan_ctrl.idx  = cmp_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fnd_addr_d = '0;
          fnd_size_d = '0;
          if (op_i == bfbc_pkg::OP_PUT) begin
            done_d = 1'b1;
            if (pool_count_q == FullCnt) begin
              status_d = bfbc_pkg::STATUS_FULL;
            end else begin
              status_d     = bfbc_pkg::STATUS_CACHED;
              mem_we       = 1'b1;
              pool_count_d = pool_count_q + CntW'(1);
            end
          end else if (pool_count_q == '0) begin
            done_d   = 1'b1;
            status_d = bfbc_pkg::STATUS_MISS;
          end else begin
            want_d        = request_size_i;
            scan_idx_d    = '0;
            scan_ctrl.clr = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_q < pool_count_q) begin
          mem_raddr  = scan_idx_q[IdxW-1:0];
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_idx_q[IdxW-1:0];
          scan_idx_d = scan_idx_q + CntW'(1);
        end else if (!cmp_vld_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (scan_res.found) begin
          mem_raddr = last_idx;
          state_d   = ST_MOVE;
        end else begin
          done_d     = 1'b1;
          status_d   = bfbc_pkg::STATUS_MISS;
          fnd_addr_d = '0;
          fnd_size_d = '0;
          state_d    = ST_IDLE;
        end
      end
      ST_MOVE: begin
        mem_we         = (scan_res.idx != last_idx);
        mem_waddr      = scan_res.idx;
        mem_wdata_addr = rd_addr_q;
        mem_wdata_size = rd_size_q;
        pool_count_d   = cnt_m1;
        done_d         = 1'b1;
        status_d       = bfbc_pkg::STATUS_HIT;
        fnd_addr_d     = scan_res.addr;
        fnd_size_d     = scan_res.size;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    held_d = (CntW >= HeldW) ? pool_count_d[HeldW-1:0] : HeldW'(pool_count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pool_count_q <= '0;
      scan_idx_q   <= '0;
      cmp_vld_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      pool_count_q <= pool_count_d;
      scan_idx_q   <= scan_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    want_q     <= want_d;
    status_q   <= status_d;
    fnd_addr_q <= fnd_addr_d;
    fnd_size_q <= fnd_size_d;
    held_q     <= held_d;
  end

  // pool storage, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[mem_waddr] <= mem_wdata_addr;
      size_mem[mem_waddr] <= mem_wdata_size;
    end
    rd_addr_q <= addr_mem[mem_raddr];
    rd_size_q <= size_mem[mem_raddr];
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_address_o = fnd_addr_q;
  assign found_size_o    = fnd_size_q;
  assign entries_held_o  = held_q;

  `ASSERT_ALWAYS(a_done_not_busy, done_q |-> !busy, "result beat while busy")
  `ASSERT_RST(a_put_grows, (accept && op_i == bfbc_pkg::OP_PUT && pool_count_q != FullCnt) |=> (pool_count_q == $past(pool_count_q) + CntW'(1)), "put did not grow pool")
  `ASSERT_RST(a_move_hits, (state_q == ST_MOVE) |=> (done_q && status_q == bfbc_pkg::STATUS_HIT), "swap-remove without hit beat")
  `ASSERT_RST(a_miss_zero, (done_q && status_q == bfbc_pkg::STATUS_MISS) |-> (fnd_addr_q == '0 && fnd_size_q == '0), "miss beat carries a block")

endmodule

// ----- sim/best_fit_block_cache_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_cache_unit_tb
// self-checking bench for the best-fit block cache
// ----------------------------------------------------------------------------
// A queue of get and put requests is filled up front: a short directed run
// over empty, full and tie cases, then random phases that lean toward puts, toward
// gets or neither, so the pool fills and drains. The driver feeds it in bursts with
// random gaps. Each accepted beat updates a local copy of the pool and queues the
// expected reply, which the monitor compares with every done_o beat.
// ----------------------------------------------------------------------------
module best_fit_block_cache_unit_tb;

  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct {
    bfbc_pkg::op_e                   op;
    logic [bfbc_pkg::SIZE_W-1:0]     size;
    logic [bfbc_pkg::ADDR_W-1:0]     addr;
  } cache_req_t;

  typedef struct {
    bfbc_pkg::status_e               status;
    logic [bfbc_pkg::ADDR_W-1:0]     addr;
    logic [bfbc_pkg::SIZE_W-1:0]     size;
    logic [bfbc_pkg::HELD_W-1:0]     held;
  } pool_reply_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            start           = 1'b0;
  logic                            op_i            = 1'b0;
  logic [bfbc_pkg::SIZE_W-1:0]     request_size_i  = '0;
  logic [bfbc_pkg::ADDR_W-1:0]     block_address_i = '0;
  logic                            busy;
  logic                            done_o;
  logic [bfbc_pkg::STATUS_W-1:0]   status_o;
  logic [bfbc_pkg::ADDR_W-1:0]     found_address_o;
  logic [bfbc_pkg::SIZE_W-1:0]     found_size_o;
  logic [bfbc_pkg::HELD_W-1:0]     entries_held_o;

  cache_req_t                      pending_q[$];
  pool_reply_t                     replies_q[$];
  logic [bfbc_pkg::ADDR_W-1:0]     cached_addr[bfbc_pkg::POOL_DEPTH];
  logic [bfbc_pkg::SIZE_W-1:0]     cached_size[bfbc_pkg::POOL_DEPTH];
  int unsigned                     cached_count = 0;
  logic [bfbc_pkg::SIZE_W-1:0]     put_sizes[$];
  int unsigned                     burst_left = 0;
  int unsigned                     gap_left   = 0;
  int unsigned                     fail_count = 0;
  int unsigned                     cycle_count = 0;

  best_fit_block_cache_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_address_o (found_address_o),
    .found_size_o    (found_size_o),
    .entries_held_o  (entries_held_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic queue_request(input bfbc_pkg::op_e op,
                               input logic [bfbc_pkg::SIZE_W-1:0] size,
                               input logic [bfbc_pkg::ADDR_W-1:0] addr);
    cache_req_t req;
    req.op   = op;
    req.size = size;
    req.addr = addr;
    pending_q.push_back(req);
    if (op == bfbc_pkg::OP_PUT) begin
      put_sizes.push_back(size);
      if (put_sizes.size() > 32) void'(put_sizes.pop_front());
    end
  endtask

  // best-fit search with swap-remove, or append on put unless the pool is full
  function automatic void apply_request(input bfbc_pkg::op_e op,
                                        input logic [bfbc_pkg::SIZE_W-1:0] size,
                                        input logic [bfbc_pkg::ADDR_W-1:0] addr);
    pool_reply_t rep;
    bit          hit;
    int unsigned best;
    rep.status = bfbc_pkg::STATUS_MISS;
    rep.addr   = '0;
    rep.size   = '0;
    hit        = 1'b0;
    best       = 0;
    if (op == bfbc_pkg::OP_GET) begin
      for (int unsigned i = 0; i < cached_count; i++) begin
        if (cached_size[i] >= size && (!hit || cached_size[i] < cached_size[best])) begin
          hit  = 1'b1;
          best = i;
        end
      end
      if (hit) begin
        rep.status        = bfbc_pkg::STATUS_HIT;
        rep.addr          = cached_addr[best];
        rep.size          = cached_size[best];
        cached_addr[best] = cached_addr[cached_count-1];
        cached_size[best] = cached_size[cached_count-1];
        cached_count--;
      end
    end else if (cached_count >= bfbc_pkg::POOL_DEPTH) begin
      rep.status = bfbc_pkg::STATUS_FULL;
    end else begin
      cached_addr[cached_count] = addr;
      cached_size[cached_count] = size;
      cached_count++;
      rep.status = bfbc_pkg::STATUS_CACHED;
    end
    rep.held = bfbc_pkg::HELD_W'(cached_count);
    replies_q.push_back(rep);
  endfunction

  function automatic logic [bfbc_pkg::SIZE_W-1:0] pick_put_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return bfbc_pkg::SIZE_W'($urandom_range(1, 64));
    if (roll < 70) return bfbc_pkg::SIZE_W'($urandom);
    if (roll < 85) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return '1;
        default: return bfbc_pkg::SIZE_W'(1) << 31;
      endcase
    end
    if (put_sizes.size() == 0) return bfbc_pkg::SIZE_W'($urandom_range(1, 64));
    return put_sizes[$urandom_range(0, put_sizes.size() - 1)];
  endfunction

  function automatic logic [bfbc_pkg::SIZE_W-1:0] pick_get_size();
    int unsigned                 roll;
    logic [bfbc_pkg::SIZE_W-1:0] base;
    int unsigned                 dec;
    roll = $urandom_range(0, 99);
    if (roll < 10 || put_sizes.size() == 0) return '0;
    base = put_sizes[$urandom_range(0, put_sizes.size() - 1)];
    if (roll < 45) return base;
    if (roll < 65) begin
      dec = $urandom_range(0, 3);
      return (base > dec) ? base - dec : '0;
    end
    if (roll < 85) return bfbc_pkg::SIZE_W'($urandom_range(0, 64));
    return bfbc_pkg::SIZE_W'($urandom);
  endfunction

  function automatic logic [bfbc_pkg::ADDR_W-1:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return bfbc_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  // stimulus and end of run
  initial begin
    int unsigned phase_left;
    int unsigned put_pct;
    int unsigned made;
    queue_request(bfbc_pkg::OP_GET, '0, '0);
    queue_request(bfbc_pkg::OP_GET, '1, '0);
    queue_request(bfbc_pkg::OP_PUT, '1, '1);
    queue_request(bfbc_pkg::OP_PUT, '0, '0);
    queue_request(bfbc_pkg::OP_PUT, 32'd100, 48'h1000);
    queue_request(bfbc_pkg::OP_PUT, 32'd100, 48'h2000);
    queue_request(bfbc_pkg::OP_PUT, 32'd50, 48'h3000);
    queue_request(bfbc_pkg::OP_GET, 32'd100, '0);
    queue_request(bfbc_pkg::OP_GET, '1, '1);
    queue_request(bfbc_pkg::OP_GET, '1, '0);
    for (int unsigned i = 0; i < 13; i++) begin
      queue_request(bfbc_pkg::OP_PUT,
                    (i == 12) ? 32'd7777 : bfbc_pkg::SIZE_W'(i * 3 + 1),
                    bfbc_pkg::ADDR_W'(48'h8000_0000 + i * 64));
    end
    queue_request(bfbc_pkg::OP_PUT, 32'd5, 48'hABCD);
    queue_request(bfbc_pkg::OP_GET, 32'd7777, '0);

    made       = 0;
    phase_left = 0;
    put_pct    = 50;
    while (made < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: put_pct = 85;
          1: put_pct = 50;
          default: put_pct = 15;
        endcase
      end
      if ($urandom_range(0, 99) < put_pct) begin
        queue_request(bfbc_pkg::OP_PUT, pick_put_size(), pick_address());
      end else begin
        queue_request(bfbc_pkg::OP_GET, pick_get_size(), pick_address());
      end
      phase_left--;
      made++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || start) @(posedge clk_i);
    while (replies_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // driver: bursts of requests with random gaps
  always @(posedge clk_i) begin : drive_requests
    bit         fire;
    cache_req_t req;
    fire = 1'b0;
    if (!rst_ni) begin
      start      <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        apply_request(bfbc_pkg::op_e'(op_i), request_size_i, block_address_i);
        fire = 1'b1;
      end
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req = pending_q.pop_front();
          start           <= 1'b1;
          op_i            <= req.op;
          request_size_i  <= req.size;
          block_address_i <= req.addr;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done beat against the oldest expected reply
  always @(posedge clk_i) begin : check_replies
    pool_reply_t rep;
    if (rst_ni && done_o) begin
      if (replies_q.size() == 0) begin
        $error("unexpected result beat, status %0d", status_o);
        fail_count++;
      end else begin
        rep = replies_q.pop_front();
        if (status_o !== rep.status) begin
          $error("status: expected %0d, actual %0d", rep.status, status_o);
          fail_count++;
        end
        if (found_address_o !== rep.addr) begin
          $error("found_address: expected %h, actual %h", rep.addr, found_address_o);
          fail_count++;
        end
        if (found_size_o !== rep.size) begin
          $error("found_size: expected %h, actual %h", rep.size, found_size_o);
          fail_count++;
        end
        if (entries_held_o !== rep.held) begin
          $error("entries_held: expected %0d, actual %0d", rep.held, entries_held_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
